### rtl/core/pmec_pkg.sv
// Types and codes shared by the power mode event controller.
`default_nettype none
package pmec_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DELAY_W     = 16;

  typedef enum logic [2:0] {
    MODE_IDLE            = 3'd0,
    MODE_SUSPENDING      = 3'd1,
    MODE_SUSPENDED       = 3'd2,
    MODE_OFF             = 3'd3,
    MODE_ERROR           = 3'd4,
    MODE_ERROR_SUSPENDED = 3'd5,
    MODE_ERROR_OFF       = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_KEEP_ALIVE   = 3'd1,
    OP_FORCE_DOWN   = 3'd2,
    OP_RESTRICT     = 3'd3,
    OP_POWER_DOWN   = 3'd4,
    OP_WAKE_UP      = 3'd5,
    OP_MODULE_STATE = 3'd6
  } op_t;

  localparam logic [1:0] LEVEL_ALIVE     = 2'd0;
  localparam logic [1:0] LEVEL_SUSPENDED = 2'd1;

  localparam logic [2:0] STATE_OFF     = 3'd0;
  localparam logic [2:0] STATE_STANDBY = 3'd1;
  localparam logic [2:0] STATE_READY   = 3'd2;
  localparam logic [2:0] STATE_ERROR   = 3'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_INACTIVITY_TIMEOUT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_DELAY        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STAY_ON            = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_ALIVE_ENABLE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_DOWN_ENABLE  = 3'd4;

  localparam logic [DELAY_W-1:0] INACTIVITY_TIMEOUT_RESET = 16'd120;
  localparam logic [DELAY_W-1:0] ERROR_DELAY_RESET        = 16'd30;

  typedef struct packed {
    logic [DELAY_W-1:0] inactivity_timeout_s;
    logic [DELAY_W-1:0] error_delay_s;
    logic               stay_on;
    logic               keep_alive_enable;
    logic               force_down_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] module_index;
    logic [1:0] allowed_level;
    logic [2:0] reported_state;
    logic       from_main;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       emit_power_down;
    logic       power_down_is_error;
    logic       emit_wake_up;
    logic       soft_off_request;
    logic       reboot_request;
    logic       consumed;
    logic       suspend_allowed;
    logic       off_allowed;
  } out_t;

endpackage
`default_nettype wire

### rtl/core/pmec_cfg.sv
// Configuration register file of the power mode event controller.
`default_nettype none
module pmec_cfg
  import pmec_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inactivity_timeout_s <= INACTIVITY_TIMEOUT_RESET;
      cfg.error_delay_s        <= ERROR_DELAY_RESET;
      cfg.stay_on              <= 1'b0;
      cfg.keep_alive_enable    <= 1'b1;
      cfg.force_down_enable    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INACTIVITY_TIMEOUT: cfg.inactivity_timeout_s <= cfg_data;
        CFG_ERROR_DELAY:        cfg.error_delay_s        <= cfg_data;
        CFG_STAY_ON:            cfg.stay_on              <= cfg_data[0];
        CFG_KEEP_ALIVE_ENABLE:  cfg.keep_alive_enable    <= cfg_data[0];
        CFG_FORCE_DOWN_ENABLE:  cfg.force_down_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/power_mode_event_controller.sv
// Power mode event controller: top level with event handling and result register.
//
// Events enter on in_valid/in_ready as one in_data word; each accepted word
// yields exactly one out_data word on out_valid/out_ready.
// Configuration words enter on cfg_valid/cfg_ready; cfg_ready is always high.
// The user must change registers only while no event is in flight; the block
// does not enforce this. The result word is valid in the cycle after its event
// is accepted. Throughput: one event per cycle while results are taken; the
// state update is a single pass of logic from the held state and the incoming
// word into the state registers and the result register.
// A waiting result does not block input if it is taken in the same cycle;
// while the receiver stalls, in_ready is low and the result word holds.
// Reset (rst, synchronous) restores the register defaults, idle mode, clear
// block masks, stopped timers and an empty result register.
`default_nettype none
module power_mode_event_controller
  import pmec_pkg::*;
#(
  parameter int MODULES      = 32,
  parameter int SECONDS_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_t                        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (SECONDS_BITS > DELAY_W) ? SECONDS_BITS : DELAY_W;

  cfg_t cfg;

  mode_t                    pm, pm_next;
  logic [MODULES-1:0]       sus_mask, sus_mask_next;
  logic [MODULES-1:0]       off_mask, off_mask_next;
  logic [SECONDS_BITS-1:0]  idle_seconds, idle_seconds_next;
  logic                     idle_armed, idle_armed_next;
  logic [DELAY_W-1:0]       err_left, err_left_next;
  logic                     err_armed, err_armed_next;
  logic                     ka_seen, ka_seen_next;

  logic [MODULES-1:0] mod_bit;
  logic               was_s, was_o, is_s, is_o;
  logic               pd, pd_err, wake, soft_off, reboot, cons;
  logic               accept;
  out_t               res;

  pmec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign mod_bit   = MODULES'(1) << in_data.module_index;

  always_comb begin
    pm_next           = pm;
    sus_mask_next     = sus_mask;
    off_mask_next     = off_mask;
    idle_seconds_next = idle_seconds;
    idle_armed_next   = idle_armed;
    err_left_next     = err_left;
    err_armed_next    = err_armed;
    ka_seen_next      = ka_seen;
    pd       = 1'b0;
    pd_err   = 1'b0;
    wake     = 1'b0;
    soft_off = 1'b0;
    reboot   = 1'b0;
    cons     = 1'b0;
    was_s  = (sus_mask == '0);
    was_o  = was_s && (off_mask == '0);
    is_s   = was_s;
    is_o   = was_o;

    case (op_t'(in_data.op))
      OP_TICK: begin
        if (idle_armed) begin
          idle_armed_next = 1'b0;
          if (ka_seen) begin
            ka_seen_next = 1'b0;
            if (pm == MODE_IDLE && was_s) begin
              idle_seconds_next = '0;
              idle_armed_next   = 1'b1;
            end
          end else begin
            if (idle_seconds != '1) begin
              idle_seconds_next = idle_seconds + 1'b1;
            end
            if (CMP_W'(idle_seconds_next) < CMP_W'(cfg.inactivity_timeout_s)) begin
              idle_armed_next = 1'b1;
            end else begin
              pd = 1'b1;
              if (pm_next == MODE_IDLE) begin
                idle_armed_next = 1'b0;
              end
              pm_next = MODE_SUSPENDING;
            end
          end
        end
        if (err_armed) begin
          if (err_left <= DELAY_W'(1)) begin
            err_left_next  = '0;
            err_armed_next = 1'b0;
            pd = 1'b1;
            if (pm_next == MODE_IDLE) begin
              idle_armed_next = 1'b0;
            end
            pm_next = MODE_ERROR_SUSPENDED;
          end else begin
            err_left_next = err_left - 1'b1;
          end
        end
      end
      OP_KEEP_ALIVE: begin
        if (cfg.keep_alive_enable) begin
          ka_seen_next = 1'b1;
        end
      end
      OP_FORCE_DOWN: begin
        if (cfg.force_down_enable && pm == MODE_IDLE) begin
          pd = 1'b1;
          idle_armed_next = 1'b0;
          pm_next = MODE_SUSPENDING;
        end
      end
      OP_RESTRICT: begin
        if (in_data.allowed_level == LEVEL_ALIVE) begin
          sus_mask_next = sus_mask | mod_bit;
        end else if (in_data.allowed_level == LEVEL_SUSPENDED) begin
          sus_mask_next = sus_mask & ~mod_bit;
          off_mask_next = off_mask | mod_bit;
        end else begin
          sus_mask_next = sus_mask & ~mod_bit;
          off_mask_next = off_mask & ~mod_bit;
        end
        is_s = (sus_mask_next == '0);
        is_o = is_s && (off_mask_next == '0);
        if (!was_s && is_s && pm == MODE_IDLE) begin
          idle_seconds_next = '0;
          idle_armed_next   = 1'b1;
        end
        if (was_s && !is_s) begin
          idle_armed_next = 1'b0;
          if (pm != MODE_IDLE) begin
            wake = 1'b1;
          end
        end
        if (!was_o && is_o && pm == MODE_SUSPENDED && !cfg.stay_on) begin
          pm_next  = MODE_OFF;
          soft_off = 1'b1;
        end
        if (was_o && !is_o && pm == MODE_OFF) begin
          reboot = 1'b1;
        end
        cons = 1'b1;
      end
      OP_POWER_DOWN: begin
        if (pm == MODE_ERROR) begin
          err_armed_next = 1'b1;
          err_left_next  = cfg.error_delay_s;
        end else if (pm == MODE_ERROR_SUSPENDED) begin
          pm_next  = MODE_ERROR_OFF;
          soft_off = 1'b1;
        end else if (pm == MODE_SUSPENDING) begin
          if (!cfg.stay_on && was_o) begin
            pm_next  = MODE_OFF;
            soft_off = 1'b1;
          end else begin
            pm_next = MODE_SUSPENDED;
          end
        end
      end
      OP_WAKE_UP: begin
        if (pm == MODE_ERROR || pm == MODE_ERROR_SUSPENDED) begin
          cons = 1'b1;
        end else begin
          if (pm == MODE_OFF || pm == MODE_ERROR_OFF) begin
            reboot = 1'b1;
          end
          pm_next = MODE_IDLE;
          if (was_s) begin
            idle_seconds_next = '0;
            idle_armed_next   = 1'b1;
          end
        end
      end
      OP_MODULE_STATE: begin
        if ((in_data.reported_state == STATE_OFF || in_data.reported_state == STATE_STANDBY)
            && (pm == MODE_SUSPENDING || pm == MODE_ERROR || pm == MODE_ERROR_SUSPENDED)) begin
          pd     = 1'b1;
          pd_err = (pm == MODE_ERROR);
        end else if (in_data.from_main && in_data.reported_state == STATE_READY) begin
          pm_next = MODE_IDLE;
          if (was_s) begin
            idle_seconds_next = '0;
            idle_armed_next   = 1'b1;
          end
        end else if (in_data.reported_state == STATE_ERROR) begin
          if (pm == MODE_IDLE) begin
            idle_armed_next = 1'b0;
          end
          pm_next = MODE_ERROR;
          pd      = 1'b1;
          pd_err  = 1'b1;
        end
      end
      default: ;
    endcase

    res.mode                = pm_next;
    res.emit_power_down     = pd;
    res.power_down_is_error = pd && pd_err;
    res.emit_wake_up        = wake;
    res.soft_off_request    = soft_off;
    res.reboot_request      = reboot;
    res.consumed            = cons;
    res.suspend_allowed     = is_s;
    res.off_allowed         = is_o;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm           <= MODE_IDLE;
      sus_mask     <= '0;
      off_mask     <= '0;
      idle_seconds <= '0;
      idle_armed   <= 1'b0;
      err_left     <= '0;
      err_armed    <= 1'b0;
      ka_seen      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        pm           <= pm_next;
        sus_mask     <= sus_mask_next;
        off_mask     <= off_mask_next;
        idle_seconds <= idle_seconds_next;
        idle_armed   <= idle_armed_next;
        err_left     <= err_left_next;
        err_armed    <= err_armed_next;
        ka_seen      <= ka_seen_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("event accepted while result word stalled");

  a_idle_timer_only_idle: assert property (@(posedge clk) disable iff (rst)
    idle_armed |-> pm == MODE_IDLE)
    else $error("inactivity timer armed outside idle");

  a_off_implies_suspend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.off_allowed || out_data.suspend_allowed)
    else $error("off allowed while suspend blocked");

  a_error_mark_needs_pd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.power_down_is_error || out_data.emit_power_down)
    else $error("error mark without power-down");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && out_data.mode == pm)
    else $error("result word does not follow accepted event");
`endif

endmodule
`default_nettype wire
